@@ hw/rtl/tesenc_pkg.sv @@
// Shared types, constants and codes for the terminal escape sequence encoder.
// Used by the controller, the datapath and the top level; depends on nothing.

package tesenc_pkg;

   // Width of each count before conversion, and the decimal digits it can need.
   localparam int VALUE_BITS = 16;
   localparam int FIELD_BITS = 16;
   localparam int DIGITS_MAX = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS   = DIGITS_MAX * 4;
   localparam int DIG_IDX_W  = $clog2(DIGITS_MAX);
   localparam int CNT_W      = $clog2(VALUE_BITS);

   // ASCII bytes of the sequences.
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_CSI   = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_J     = 8'h4A;
   localparam logic [7:0] CH_X     = 8'h58;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // Command codes; the remaining code carries no command.
   typedef enum logic [2:0] {
      OP_SAVE    = 3'd0,
      OP_RESTORE = 3'd1,
      OP_SET_POS = 3'd2,
      OP_ERASE   = 3'd3,
      OP_CLEAR   = 3'd4,
      OP_BACK    = 3'd5,
      OP_INSERT  = 3'd6
   } op_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_ESC,
      ST_INTRO,
      ST_CLR,
      ST_NUM_A,
      ST_SEP,
      ST_NUM_B,
      ST_FINAL
   } state_type;

   // Source of the byte loaded into the output register.
   typedef enum logic [2:0] {
      SEL_ESC,
      SEL_INTRO,
      SEL_TWO,
      SEL_DIGIT_A,
      SEL_SEMI,
      SEL_DIGIT_B,
      SEL_FINAL
   } byte_sel_type;

   typedef struct packed {
      logic [2:0]            op;
      logic [FIELD_BITS-1:0] first_value;
      logic [FIELD_BITS-1:0] second_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic         capture;
      logic         conv_step;
      logic         ptr_load;
      logic         dec_a;
      logic         dec_b;
      logic         load;
      logic         last;
      byte_sel_type sel;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [2:0] op;
      logic       conv_last;
      logic       a_done;
      logic       b_done;
   } status_type;

endpackage

@@ hw/rtl/tesenc_datapath.sv @@
// Datapath of the escape sequence encoder: command register, two shift-add-3
// binary to decimal converters, digit pointers and the output beat register.
// Depends on tesenc_pkg.

module tesenc_datapath
   import tesenc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   logic [2:0]            op_ff, op_in;
   logic [VALUE_BITS-1:0] bin_a_ff, bin_a_in, bin_b_ff, bin_b_in;
   logic [BCD_BITS-1:0]   bcd_a_ff, bcd_a_in, bcd_b_ff, bcd_b_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIG_IDX_W-1:0]  ptr_a_ff, ptr_a_in, ptr_b_ff, ptr_b_in;
   logic [DIG_IDX_W-1:0]  lead_a, lead_b;
   rsp_type               rsp_ff, rsp_in;
   logic [7:0]            intro_byte, final_byte, digit_a_byte, digit_b_byte;

   // One shift-add-3 step: correct every digit of five or more, then shift.
   function automatic logic [BCD_BITS-1:0] dabble(input logic [BCD_BITS-1:0] bcd,
                                                  input logic              bit_in);
      logic [BCD_BITS-1:0] adj;
      adj = bcd;
      for (int i = 0; i < DIGITS_MAX; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return {adj[BCD_BITS-2:0], bit_in};
   endfunction

   // Position of the most significant non-zero digit, or zero for a zero value.
   function automatic logic [DIG_IDX_W-1:0] lead_digit(input logic [BCD_BITS-1:0] bcd);
      logic [DIG_IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < DIGITS_MAX; i++) begin
         if (bcd[4*i +: 4] != 4'd0) begin
            idx = DIG_IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // Conversion and command capture.
   always_comb begin
      op_in    = op_ff;
      bin_a_in = bin_a_ff;
      bin_b_in = bin_b_ff;
      bcd_a_in = bcd_a_ff;
      bcd_b_in = bcd_b_ff;
      cnt_in   = cnt_ff;
      if (cmd.capture) begin
         op_in    = req_data.op;
         bin_a_in = req_data.first_value[VALUE_BITS-1:0];
         bin_b_in = req_data.second_value[VALUE_BITS-1:0];
         bcd_a_in = '0;
         bcd_b_in = '0;
         cnt_in   = CNT_W'(VALUE_BITS - 1);
      end else if (cmd.conv_step) begin
         bcd_a_in = dabble(bcd_a_ff, bin_a_ff[VALUE_BITS-1]);
         bcd_b_in = dabble(bcd_b_ff, bin_b_ff[VALUE_BITS-1]);
         bin_a_in = {bin_a_ff[VALUE_BITS-2:0], 1'b0};
         bin_b_in = {bin_b_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
      end
   end

   // Digit pointers walk from the leading digit down to the units.
   assign lead_a = lead_digit(bcd_a_ff);
   assign lead_b = lead_digit(bcd_b_ff);

   always_comb begin
      ptr_a_in = ptr_a_ff;
      ptr_b_in = ptr_b_ff;
      if (cmd.ptr_load) begin
         ptr_a_in = lead_a;
         ptr_b_in = lead_b;
      end else begin
         if (cmd.dec_a) begin
            ptr_a_in = ptr_a_ff - 1'b1;
         end
         if (cmd.dec_b) begin
            ptr_b_in = ptr_b_ff - 1'b1;
         end
      end
   end

   // Bytes that depend on the command.
   always_comb begin
      unique case (op_ff)
         OP_SAVE:    intro_byte = CH_SEVEN;
         OP_RESTORE: intro_byte = CH_EIGHT;
         default:    intro_byte = CH_CSI;
      endcase
   end

   always_comb begin
      unique case (op_ff)
         OP_SET_POS: final_byte = CH_H;
         OP_ERASE:   final_byte = CH_X;
         OP_CLEAR:   final_byte = CH_J;
         OP_BACK:    final_byte = CH_D;
         default:    final_byte = CH_AT;
      endcase
   end

   assign digit_a_byte = CH_ZERO | {4'd0, bcd_a_ff[4*ptr_a_ff +: 4]};
   assign digit_b_byte = CH_ZERO | {4'd0, bcd_b_ff[4*ptr_b_ff +: 4]};

   // Output beat register.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load) begin
         rsp_in.last = cmd.last;
         unique case (cmd.sel)
            SEL_ESC:     rsp_in.out_byte = CH_ESC;
            SEL_INTRO:   rsp_in.out_byte = intro_byte;
            SEL_TWO:     rsp_in.out_byte = CH_TWO;
            SEL_DIGIT_A: rsp_in.out_byte = digit_a_byte;
            SEL_SEMI:    rsp_in.out_byte = CH_SEMI;
            SEL_DIGIT_B: rsp_in.out_byte = digit_b_byte;
            default:     rsp_in.out_byte = final_byte;
         endcase
      end
   end

   // Counter is control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      bin_a_ff <= bin_a_in;
      bin_b_ff <= bin_b_in;
      bcd_a_ff <= bcd_a_in;
      bcd_b_ff <= bcd_b_in;
      ptr_a_ff <= ptr_a_in;
      ptr_b_ff <= ptr_b_in;
      rsp_ff   <= rsp_in;
   end

   assign status.op        = op_ff;
   assign status.conv_last = (cnt_ff == '0);
   assign status.a_done    = (ptr_a_ff == '0);
   assign status.b_done    = (ptr_b_ff == '0);
   assign rsp_data         = rsp_ff;

endmodule

@@ hw/rtl/tesenc_controller.sv @@
// Controller of the escape sequence encoder: sequences conversion and byte
// emission, and owns the output valid flag. Depends on tesenc_pkg.

module tesenc_controller
   import tesenc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_op,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      go;
   logic      req_known, req_has_num, op_has_num, op_short;

   // The output register can take a beat when empty or being emptied.
   assign go = !rsp_valid_ff || !rsp_stall;

   assign req_known   = (req_op <= OP_INSERT);
   assign req_has_num = (req_op == OP_SET_POS) || (req_op == OP_ERASE) ||
                        (req_op == OP_BACK) || (req_op == OP_INSERT);
   assign op_has_num  = (status.op == OP_SET_POS) || (status.op == OP_ERASE) ||
                        (status.op == OP_BACK) || (status.op == OP_INSERT);
   assign op_short    = (status.op == OP_SAVE) || (status.op == OP_RESTORE);

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.sel   = SEL_ESC;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && req_known) begin
               cmd.capture = 1'b1;
               state_in    = req_has_num ? ST_CONV : ST_ESC;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_last) begin
               state_in = ST_ESC;
            end
         end
         ST_ESC: begin
            cmd.ptr_load = 1'b1;
            cmd.sel      = SEL_ESC;
            cmd.load     = go;
            if (go) begin
               state_in = ST_INTRO;
            end
         end
         ST_INTRO: begin
            cmd.sel  = SEL_INTRO;
            cmd.last = op_short;
            cmd.load = go;
            if (go) begin
               if (op_short) begin
                  state_in = ST_IDLE;
               end else if (op_has_num) begin
                  state_in = ST_NUM_A;
               end else begin
                  state_in = ST_CLR;
               end
            end
         end
         ST_CLR: begin
            cmd.sel  = SEL_TWO;
            cmd.load = go;
            if (go) begin
               state_in = ST_FINAL;
            end
         end
         ST_NUM_A: begin
            cmd.sel   = SEL_DIGIT_A;
            cmd.load  = go;
            cmd.dec_a = go && !status.a_done;
            if (go && status.a_done) begin
               state_in = (status.op == OP_SET_POS) ? ST_SEP : ST_FINAL;
            end
         end
         ST_SEP: begin
            cmd.sel  = SEL_SEMI;
            cmd.load = go;
            if (go) begin
               state_in = ST_NUM_B;
            end
         end
         ST_NUM_B: begin
            cmd.sel   = SEL_DIGIT_B;
            cmd.load  = go;
            cmd.dec_b = go && !status.b_done;
            if (go && status.b_done) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.sel  = SEL_FINAL;
            cmd.last = 1'b1;
            cmd.load = go;
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The valid flag stays while the beat is stalled and is set by each load.
   assign rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A closing beat always returns the controller to idle.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("closing beat did not return to idle");

   // No beat is loaded while the converters are running.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !cmd.load)
      else $error("beat loaded during conversion");

   // Only count-bearing commands reach the digit states.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_NUM_A) || (state_ff == ST_NUM_B)) |-> op_has_num)
      else $error("digit state reached by a command without a count");

   // An unknown command code is dropped and leaves the controller idle.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && req_valid && !req_known) |=> (state_ff == ST_IDLE))
      else $error("unknown command code was not dropped");

endmodule

@@ hw/rtl/terminal_escape_sequence_encoder_core.sv @@
// Channel  Direction  Payload   Handshake
// req      in         req_type  req_valid / req_stall
// rsp      out        rsp_type  rsp_valid / rsp_stall
//
// One command is taken at a time. A command with a count first passes through
// the shift-add-3 converters (both counts in parallel), then emits one byte a
// cycle while the output is not stalled; save, restore and clear screen skip
// the conversion. An unknown code is taken and gives no bytes. Reset is
// synchronous and empties the output register; a stalled beat holds while the
// next command may still be taken.
// Top level: joins the controller and the datapath. Depends on tesenc_pkg,
// tesenc_controller and tesenc_datapath.

module terminal_escape_sequence_encoder_core
   import tesenc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencing.
   tesenc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Conversion and byte generation.
   tesenc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
